/* sv/erpd_pkg.sv */
// shared types and constants for the escaped run-length page decoder
// no dependencies; imported by every module of the block
`default_nettype none

package erpd_pkg;

  // escape byte of the compressed stream
  localparam logic [7:0] ESC_BYTE = 8'hED;

  // page length after reset
  localparam logic [14:0] PAGE_LENGTH_RESET = 15'h4000;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // escape state of the front
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_ESC2  = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_t;

  // one decoded result
  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] repeat_count;
    logic       page_full;
  } result_t;

  // all results caused by one input byte; the second always has count 1
  typedef struct packed {
    result_t    first;
    logic       two;
    logic [7:0] second_value;
    logic       second_full;
  } entry_t;

endpackage

`default_nettype wire

/* sv/erpd_if.sv */
// channel interfaces of the decoder: compressed input and decoded results
// no dependencies
`default_nettype none

interface erpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;
  logic       end_of_page;

  modport source(output valid, compressed_byte, end_of_page, input ready);
  modport sink(input valid, compressed_byte, end_of_page, output ready);
endinterface

interface erpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [7:0] repeat_count;
  logic       last_of_item;
  logic       page_full;

  modport source(output valid, byte_value, repeat_count, last_of_item, page_full,
                 input ready);
  modport sink(input valid, byte_value, repeat_count, last_of_item, page_full,
               output ready);
endinterface

`default_nettype wire

/* sv/erpd_front.sv */
// front of the decoder: escape state, page position, clipping of runs
// depends on erpd_pkg and erpd_in_if
`default_nettype none

module erpd_front #(
  parameter int MAX_PAGE_BYTES = 16384
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  erpd_in_if.sink             in_ch,
  input  wire logic           cfg_we,
  input  wire logic [14:0]    cfg_wdata,
  input  wire logic           q_full,
  output logic                q_push,
  output erpd_pkg::entry_t    q_entry
);
  import erpd_pkg::*;

  localparam int PW = $clog2(MAX_PAGE_BYTES + 1);
  localparam int LW = (PW > 15) ? PW : 15;

  logic [14:0]   page_length_r;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic          accept;
  logic [7:0]    b;
  logic          eop;
  logic [LW-1:0] plen_ext, eff_len, pos_ext, room, pos1, pos2;
  logic          active;
  logic          want0, pair, emit0, emit1, full0, full1;
  logic [7:0]    val0, cnt0, clipped;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.compressed_byte;
  assign eop         = in_ch.end_of_page;

  // effective page length clamped to 1..MAX_PAGE_BYTES
  always_comb begin
    plen_ext = LW'(page_length_r);
    if (plen_ext == '0) begin
      eff_len = LW'(1);
    end else if (plen_ext > LW'(MAX_PAGE_BYTES)) begin
      eff_len = LW'(MAX_PAGE_BYTES);
    end else begin
      eff_len = plen_ext;
    end
  end

  assign pos_ext = LW'(pos_r);
  assign active  = pos_ext < eff_len;

  // escape state step and what it wants to emit
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    want0     = 1'b0;
    pair      = 1'b0;
    val0      = b;
    cnt0      = 8'd1;
    if (active) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b != ESC_BYTE) begin
            want0 = 1'b1;
          end else if (eop) begin
            want0 = 1'b1;
            val0  = ESC_BYTE;
          end else begin
            phase_nxt = PH_ESC;
          end
        end
        PH_ESC: begin
          if (b != ESC_BYTE) begin
            want0     = 1'b1;
            val0      = ESC_BYTE;
            pair      = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_ESC2;
          end
        end
        PH_ESC2: begin
          pend_nxt  = b;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          want0     = 1'b1;
          cnt0      = pend_r;
          pend_nxt  = 8'd0;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (eop) begin
      phase_nxt = PH_IDLE;
      pend_nxt  = 8'd0;
    end
  end

  // clip against the room left in the page
  always_comb begin
    room    = eff_len - pos_ext;
    clipped = (LW'(cnt0) > room) ? room[7:0] : cnt0;
    emit0   = want0 && (cnt0 != 8'd0);
    pos1    = pos_ext + LW'(clipped);
    full0   = pos1 >= eff_len;
    emit1   = emit0 && pair && !full0;
    pos2    = pos1 + LW'(1);
    full1   = pos2 >= eff_len;
    if (eop) begin
      pos_nxt = '0;
    end else if (emit1) begin
      pos_nxt = PW'(pos2);
    end else if (emit0) begin
      pos_nxt = PW'(pos1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  // queue entry for this byte
  always_comb begin
    q_entry.first.byte_value   = val0;
    q_entry.first.repeat_count = clipped;
    q_entry.first.page_full    = full0;
    q_entry.two                = emit1;
    q_entry.second_value       = b;
    q_entry.second_full        = full1;
  end

  assign q_push = accept && emit0;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_length_r <= PAGE_LENGTH_RESET;
      phase_r       <= PH_IDLE;
      pend_r        <= 8'd0;
      pos_r         <= '0;
    end else begin
      if (cfg_we) begin
        page_length_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/erpd_queue.sv */
// short queue of decoded entries between front and back
// depends on erpd_pkg
`default_nettype none

module erpd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire erpd_pkg::entry_t push_entry,
  input  wire logic             pop,
  output erpd_pkg::entry_t      head,
  output logic                  empty,
  output logic                  full
);
  import erpd_pkg::*;

  entry_t          mem_r [QDEPTH];
  logic [QAW-1:0]  wptr_r, rptr_r;
  logic [QAW:0]    count_r, count_nxt;

  assign empty = count_r == '0;
  assign full  = count_r == (QAW+1)'(QDEPTH);
  assign head  = mem_r[rptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/erpd_back.sv */
// back of the decoder: delivers the one or two results of each queue entry
// depends on erpd_pkg and erpd_out_if
`default_nettype none

module erpd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire erpd_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  erpd_out_if.source            out_ch
);
  import erpd_pkg::*;

  logic sub_r, sub_nxt;
  logic accept;

  assign out_ch.valid = !empty;
  assign accept       = out_ch.valid && out_ch.ready;

  // select the result of the head entry
  always_comb begin
    if (sub_r) begin
      out_ch.byte_value   = head.second_value;
      out_ch.repeat_count = 8'd1;
      out_ch.page_full    = head.second_full;
      out_ch.last_of_item = 1'b1;
    end else begin
      out_ch.byte_value   = head.first.byte_value;
      out_ch.repeat_count = head.first.repeat_count;
      out_ch.page_full    = head.first.page_full;
      out_ch.last_of_item = !head.two;
    end
  end

  // step through the entry, pop after its last result
  assign pop     = accept && (sub_r || !head.two);
  assign sub_nxt = accept ? (!sub_r && head.two) : sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/escaped_rle_page_decoder_top.sv */
// top level of the escaped run-length page decoder
// depends on erpd_pkg, erpd_if, erpd_front, erpd_queue, erpd_back
//
// usage
//   in_ch carries one compressed byte per transaction with end_of_page set on
//   the last byte of a page. out_ch carries decoded results: a byte value and
//   a repeat count already clipped to the page, last_of_item on the final
//   result of an input byte and page_full once the page length is reached.
//   cfg_we/cfg_wdata write page_length; write it only while the block is idle.
// timing
//   a result passes through the queue's storage registers before it is offered on out_ch.
//   the front takes one byte per cycle unless the queue is full; the back
//   delivers one result per cycle while out_ch.ready is high, so a byte
//   that decodes into two results takes two output transfers. a four-entry
//   queue between front and back sets how many bytes can be taken while the
//   receiver stalls; in_ch.ready drops only when that queue is full.
// reset
//   rst_n (synchronous, active low) empties the queue, returns the escape
//   state and page position to the start of a page and page_length to 16384.
`default_nettype none

module escaped_rle_page_decoder_top #(
  parameter int MAX_PAGE_BYTES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  erpd_in_if.sink          in_ch,
  erpd_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [14:0] cfg_wdata
);
  import erpd_pkg::*;

  logic   q_push, q_pop, q_empty, q_full;
  entry_t q_in, q_head;

  // classify bytes and clip runs
  erpd_front #(
    .MAX_PAGE_BYTES(MAX_PAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decouple front and back
  erpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // deliver results
  erpd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .out_ch(out_ch)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("queue push while full");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.repeat_count != 8'd0)
    else $error("result with zero repeat count");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.page_full |-> out_ch.last_of_item)
    else $error("result after the page filled");

  a_pop_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> out_ch.valid && out_ch.ready && out_ch.last_of_item)
    else $error("queue popped without delivering the last result");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench for escaped_rle_page_decoder_top: queued stimulus, a byte-by-byte decode
// predictor and a result checker, with random stalls on both channels
// depends on erpd_pkg, erpd_if and the decoder RTL
module tb;
  import erpd_pkg::*;

  localparam int MAX_PAGE_BYTES = 16384;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] value;
    logic       eop;
  } page_byte_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] repeat_count;
    logic       last_of_item;
    logic       page_full;
  } decoded_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [14:0] cfg_wdata = '0;

  logic       in_valid = 1'b0;
  logic [7:0] in_byte  = '0;
  logic       in_eop   = 1'b0;
  logic       out_ready = 1'b0;

  erpd_in_if  in_ch();
  erpd_out_if out_ch();

  assign in_ch.valid           = in_valid;
  assign in_ch.compressed_byte = in_byte;
  assign in_ch.end_of_page     = in_eop;
  assign out_ch.ready          = out_ready;

  escaped_rle_page_decoder_top #(.MAX_PAGE_BYTES(MAX_PAGE_BYTES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // stimulus and expectation stores
  page_byte_t compressed_q [$];
  decoded_t   expected_runs [$];
  int         bytes_queued = 0;
  int         mismatches   = 0;

  // traffic shaping controls, set from the sequence at falling edges
  bit no_idle    = 1'b0;
  int hold_asks  = 0;
  int holds_done = 0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  // decoder model state
  logic [14:0] model_page_len = PAGE_LENGTH_RESET;
  phase_t      esc_phase      = PH_IDLE;
  logic [7:0]  held_count     = '0;
  int unsigned out_pos        = 0;
  decoded_t    item_res [2];
  int          item_n;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // page length with out-of-range settings clamped
  function automatic int unsigned page_limit();
    int unsigned len;
    len = 32'(model_page_len);
    if (len < 1) len = 1;
    if (len > MAX_PAGE_BYTES) len = MAX_PAGE_BYTES;
    return len;
  endfunction

  // record one run, clipped to the room left in the page
  function automatic void add_run(input logic [7:0] val, input int unsigned cnt);
    int unsigned len;
    decoded_t    r;
    len = page_limit();
    if (out_pos >= len || cnt == 0) return;
    if (cnt > len - out_pos) cnt = len - out_pos;
    out_pos += cnt;
    r.byte_value   = val;
    r.repeat_count = cnt[7:0];
    r.last_of_item = 1'b0;
    r.page_full    = (out_pos >= len);
    item_res[item_n] = r;
    item_n++;
  endfunction

  // escape state machine step for one accepted compressed byte
  function automatic void decode_byte(input logic [7:0] b, input logic eop);
    item_n = 0;
    if (out_pos < page_limit()) begin
      case (esc_phase)
        PH_IDLE: begin
          if (b != ESC_BYTE) add_run(b, 1);
          else if (eop) add_run(ESC_BYTE, 1);
          else esc_phase = PH_ESC;
        end
        PH_ESC: begin
          if (b != ESC_BYTE) begin
            add_run(ESC_BYTE, 1);
            add_run(b, 1);
            esc_phase = PH_IDLE;
          end else begin
            esc_phase = PH_ESC2;
          end
        end
        PH_ESC2: begin
          held_count = b;
          esc_phase  = PH_COUNT;
        end
        default: begin
          add_run(b, 32'(held_count));
          held_count = '0;
          esc_phase  = PH_IDLE;
        end
      endcase
    end
    if (item_n > 0) item_res[item_n - 1].last_of_item = 1'b1;
    for (int i = 0; i < item_n; i++) expected_runs.push_back(item_res[i]);
    // end of page returns everything to the start of a page
    if (eop) begin
      esc_phase  = PH_IDLE;
      held_count = '0;
      out_pos    = 0;
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // input driver: tracks config writes, predicts accepted transactions
  always @(posedge clk) begin
    page_byte_t nxt;
    if (cfg_we) model_page_len = cfg_wdata;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) decode_byte(in_byte, in_eop);
      if (!in_valid || in_ch.ready) begin
        if (compressed_q.size() != 0 && (no_idle || $urandom_range(99) >= 27)) begin
          nxt = compressed_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.value;
          in_eop   <= nxt.eop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_ch.valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d count %0d",
                 $time, out_ch.byte_value, out_ch.repeat_count);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        check_field("byte_value", 32'(want.byte_value), 32'(out_ch.byte_value));
        check_field("repeat_count", 32'(want.repeat_count), 32'(out_ch.repeat_count));
        check_field("last_of_item", 32'(want.last_of_item), 32'(out_ch.last_of_item));
        check_field("page_full", 32'(want.page_full), 32'(out_ch.page_full));
      end
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_asks) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ch.ready) || (out_ch.valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** escaped_rle_page_decoder_top: FAILED **");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] v, input logic eop);
    page_byte_t pb;
    pb.value = v;
    pb.eop   = eop;
    compressed_q.push_back(pb);
    bytes_queued++;
  endtask

  // wait until everything sent has been decoded and checked
  task automatic wait_idle();
    while (compressed_q.size() != 0 || in_valid || expected_runs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_page_length(input logic [14:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed tokens with random content, some noise and cut endings
  task automatic add_page(input int tokens, input bit close);
    int         kind;
    logic [7:0] v;
    logic [7:0] cnt;
    for (int i = 0; i < tokens; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        do v = 8'($urandom_range(255)); while (v == ESC_BYTE);
        add_byte(v, 1'b0);
      end else if (kind < 70) begin
        case ($urandom_range(9))
          0: cnt = 8'd0;
          1: cnt = 8'd255;
          default: cnt = 8'($urandom_range(1, 255));
        endcase
        add_byte(ESC_BYTE, 1'b0);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(cnt, 1'b0);
        add_byte(8'($urandom_range(255)), 1'b0);
      end else if (kind < 85) begin
        do v = 8'($urandom_range(255)); while (v == ESC_BYTE);
        add_byte(ESC_BYTE, 1'b0);
        add_byte(v, 1'b0);
      end else begin
        add_byte(8'($urandom_range(255)), 1'b0);
      end
    end
    if (close) begin
      case ($urandom_range(4))
        0: add_byte(ESC_BYTE, 1'b1);
        1: begin
          add_byte(ESC_BYTE, 1'b0);
          add_byte(ESC_BYTE, 1'b1);
        end
        2: begin
          add_byte(ESC_BYTE, 1'b0);
          add_byte(ESC_BYTE, 1'b0);
          add_byte(8'($urandom_range(255)), 1'b1);
        end
        default: add_byte(8'($urandom_range(255)), 1'b1);
      endcase
    end
  endtask

  initial begin
    logic [14:0] phase_len [7];
    int          target;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // literal, escaped pair, zero-count run, full run of 0xff
    add_byte(8'h00, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    // lone escape closing the page
    add_byte(ESC_BYTE, 1'b1);
    // run cut short by end of page
    add_byte(ESC_BYTE, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h05, 1'b1);
    wait_idle();

    // zero length acts as one byte; the rest of the page is dropped
    write_page_length(15'd0);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b1);
    wait_idle();

    // run clipped to a short page
    write_page_length(15'd3);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h0A, 1'b0);
    add_byte(8'h77, 1'b1);
    wait_idle();

    // escape fills the page so its partner byte is dropped
    write_page_length(15'd1);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h42, 1'b1);
    wait_idle();

    // length lowered below the current position mid-page
    write_page_length(15'd16384);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h03, 1'b0);
    wait_idle();
    write_page_length(15'd2);
    add_byte(8'h04, 1'b1);
    wait_idle();

    // oversized setting clamps to the largest page, filled by full runs
    write_page_length(15'h7FFF);
    for (int i = 0; i < 66; i++) begin
      add_byte(ESC_BYTE, 1'b0);
      add_byte(ESC_BYTE, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'($urandom_range(255)), 1'b0);
    end
    add_byte(8'($urandom_range(255)), 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'($urandom_range(255)), 1'b1);
    wait_idle();

    // random phases over several page lengths
    phase_len[0] = 15'd1;
    phase_len[1] = 15'($urandom_range(3, 40));
    phase_len[2] = 15'd0;
    phase_len[3] = 15'($urandom_range(41, 600));
    phase_len[4] = 15'd16384;
    phase_len[5] = 15'($urandom_range(0, 32767));
    phase_len[6] = 15'd2;
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_page_length(phase_len[p]);
      no_idle = (p == 3);
      if (p == 1) hold_asks++;
      target = bytes_queued + 95;
      while (bytes_queued < target)
        add_page($urandom_range(1, 10), $urandom_range(7) != 0);
    end

    wait_idle();
    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("** escaped_rle_page_decoder_top: PASSED **");
    end else begin
      $display("** escaped_rle_page_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
